@@ rtl/rtv_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtv_pkg
// shared types and constants of the rgb to hsv converter
// ----------------------------------------------------------------------------
package rtv_pkg;

    localparam int CH_W      = 8;   // input channel width
    localparam int HUE_W     = 16;  // hue fraction width
    localparam int SAT_W     = 16;  // saturation fraction width
    localparam int NUM_W     = 11;  // hue numerator / divisor width, 6*255 < 2048
    localparam int DIV_STEPS = 16;  // quotient bits, one per divider stage

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rtv_pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] saturation;
        logic [CH_W-1:0]  brightness;
    } rtv_color_t;

    // classified pixel, ready for the two dividers
    typedef struct packed {
        logic [CH_W-1:0]  brightness;
        logic [CH_W-1:0]  delta;
        logic [NUM_W-1:0] hue_num;
        logic [NUM_W-1:0] hue_den;
    } rtv_work_t;

endpackage
`default_nettype wire

@@ rtl/rtv_stream_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtv_stream_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface rtv_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface
`default_nettype wire

@@ rtl/rtv_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtv_front
// finds max, min and the dominant channel and forms the hue numerator and divisor
// ----------------------------------------------------------------------------
module rtv_front
    import rtv_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    rtv_stream_if.sink   pixel,
    rtv_stream_if.source work
);

    logic             f_valid_reg;
    logic             f_valid_next;
    rtv_work_t        f_item_reg;
    rtv_work_t        f_item_next;
    logic             accept;

    logic [CH_W-1:0]  r;
    logic [CH_W-1:0]  g;
    logic [CH_W-1:0]  b;
    logic [CH_W-1:0]  mx;
    logic [CH_W-1:0]  mn;
    logic [CH_W-1:0]  delta;
    logic [NUM_W-1:0] d_ext;
    logic [NUM_W-1:0] r_ext;
    logic [NUM_W-1:0] g_ext;
    logic [NUM_W-1:0] b_ext;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;

    assign pixel.ready = !f_valid_reg || work.ready;
    assign accept      = pixel.valid && pixel.ready;
    assign work.valid  = f_valid_reg;
    assign work.data   = f_item_reg;

    always_comb
    begin
        r = pixel.data.red;
        g = pixel.data.green;
        b = pixel.data.blue;

        mx = r;
        if (g > mx)
        begin
            mx = g;
        end
        if (b > mx)
        begin
            mx = b;
        end
        mn = r;
        if (g < mn)
        begin
            mn = g;
        end
        if (b < mn)
        begin
            mn = b;
        end
        delta = mx - mn;

        d_ext = {{(NUM_W-CH_W){1'b0}}, delta};
        r_ext = {{(NUM_W-CH_W){1'b0}}, r};
        g_ext = {{(NUM_W-CH_W){1'b0}}, g};
        b_ext = {{(NUM_W-CH_W){1'b0}}, b};
        den   = (d_ext << 2) + (d_ext << 1);

        // offset*delta always covers a negative difference, so modulo
        // arithmetic on NUM_W bits gives the true value
        if (mx == r)
        begin
            if (g < b)
            begin
                num = den - (b_ext - g_ext);
            end
            else
            begin
                num = g_ext - b_ext;
            end
        end
        else if (mx == g)
        begin
            num = (d_ext << 1) + b_ext - r_ext;
        end
        else
        begin
            num = (d_ext << 2) + r_ext - g_ext;
        end

        f_item_next.brightness = mx;
        f_item_next.delta      = delta;
        f_item_next.hue_num    = num;
        f_item_next.hue_den    = den;
    end

    assign f_valid_next = accept || (f_valid_reg && !work.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_item_reg <= f_item_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/rtv_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtv_queue
// short first-in first-out buffer between front and back
// ----------------------------------------------------------------------------
module rtv_queue
    import rtv_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rtv_stream_if.sink   push,
    rtv_stream_if.source pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rtv_work_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push.ready = (count_reg != FULL_CNT);
    assign pop.valid  = (count_reg != '0);
    assign pop.data   = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && push.ready;
    assign do_pop     = pop.valid && pop.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.data;
        end
    end

endmodule
`default_nettype wire

@@ rtl/rtv_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtv_back
// two pipelined restoring dividers, one quotient bit per stage
// ----------------------------------------------------------------------------
module rtv_back
    import rtv_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    rtv_stream_if.sink   work,
    rtv_stream_if.source color
);

    localparam int SAT_N_W = CH_W + SAT_W;

    logic                valid_reg   [DIV_STEPS+1];
    logic [CH_W-1:0]     bright_reg  [DIV_STEPS+1];
    logic                zero_reg    [DIV_STEPS+1];
    logic [CH_W-1:0]     sat_rem_reg [DIV_STEPS+1];
    logic [SAT_W-1:0]    sat_dvd_reg [DIV_STEPS+1];
    logic [NUM_W-1:0]    hue_rem_reg [DIV_STEPS+1];
    logic [NUM_W-1:0]    hue_den_reg [DIV_STEPS+1];
    logic [HUE_W-1:0]    hue_q_reg   [DIV_STEPS+1];

    logic                pipe_en;
    logic [SAT_N_W-1:0]  sat_n;

    // whole pipeline moves unless the result sits untaken
    assign pipe_en    = !valid_reg[DIV_STEPS] || color.ready;
    assign work.ready = pipe_en;

    // delta * 65535 = (delta << 16) - delta
    assign sat_n = {work.data.delta, {SAT_W{1'b0}}}
                 - {{SAT_W{1'b0}}, work.data.delta};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (pipe_en)
        begin
            valid_reg[0] <= work.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            bright_reg[0]  <= work.data.brightness;
            zero_reg[0]    <= (work.data.delta == '0);
            sat_rem_reg[0] <= sat_n[SAT_N_W-1:SAT_W];
            sat_dvd_reg[0] <= sat_n[SAT_W-1:0];
            hue_rem_reg[0] <= work.data.hue_num;
            hue_den_reg[0] <= work.data.hue_den;
            hue_q_reg[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_step
        logic [CH_W:0]    sat_trial;
        logic             sat_ge;
        logic [NUM_W:0]   hue_trial;
        logic             hue_ge;
        logic [CH_W-1:0]  sat_rem_next;
        logic [NUM_W-1:0] hue_rem_next;

        always_comb
        begin
            sat_trial    = {sat_rem_reg[k-1], sat_dvd_reg[k-1][SAT_W-1]};
            sat_ge       = (sat_trial >= {1'b0, bright_reg[k-1]});
            sat_rem_next = sat_ge ? CH_W'(sat_trial - {1'b0, bright_reg[k-1]})
                                  : sat_trial[CH_W-1:0];
            hue_trial    = {hue_rem_reg[k-1], 1'b0};
            hue_ge       = (hue_trial >= {1'b0, hue_den_reg[k-1]});
            hue_rem_next = hue_ge ? NUM_W'(hue_trial - {1'b0, hue_den_reg[k-1]})
                                  : hue_trial[NUM_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (pipe_en)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                bright_reg[k]  <= bright_reg[k-1];
                zero_reg[k]    <= zero_reg[k-1];
                sat_rem_reg[k] <= sat_rem_next;
                sat_dvd_reg[k] <= {sat_dvd_reg[k-1][SAT_W-2:0], sat_ge};
                hue_rem_reg[k] <= hue_rem_next;
                hue_den_reg[k] <= hue_den_reg[k-1];
                hue_q_reg[k]   <= {hue_q_reg[k-1][HUE_W-2:0], hue_ge};
            end
        end
    end

    // gray and black pixels give zero hue and saturation
    assign color.valid           = valid_reg[DIV_STEPS];
    assign color.data.brightness = bright_reg[DIV_STEPS];
    assign color.data.saturation = zero_reg[DIV_STEPS] ? '0 : sat_dvd_reg[DIV_STEPS];
    assign color.data.hue        = zero_reg[DIV_STEPS] ? '0 : hue_q_reg[DIV_STEPS];

endmodule
`default_nettype wire

@@ rtl/rgb_to_hsv_converter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit
// rgb to hsv pixel converter with a one pixel per clock stream interface
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one hsv result per pixel, in order.
// Brightness is the largest channel, saturation is floor(delta*65535/max)
// and hue is a 16-bit fraction of a full turn; gray and black pixels give
// zero hue and saturation. Sustained rate is one pixel per clock cycle while the result channel does not stall.
// A pixel passes from its input transaction to its result through the front
// classifier register, the queue and the back end, whose input register
// feeds two restoring dividers that resolve one quotient bit per pipeline
// stage over 16 stages. Back pressure on the result channel freezes the
// back end; the queue of QUEUE_DEPTH entries lets the front keep taking
// pixels until it fills.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_unit
    import rtv_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4  // entries between front and back, at least 2
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    rtv_stream_if.sink   pixel,   // rtv_pixel_t payload
    rtv_stream_if.source color    // rtv_color_t payload
);

    // classified pixels leave the front here
    rtv_stream_if #(.payload_t(rtv_work_t)) front_q ();
    // and enter the dividers here
    rtv_stream_if #(.payload_t(rtv_work_t)) queue_b ();

    // front: max/min, dominant channel, hue numerator and divisor
    rtv_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel),
        .work  (front_q)
    );

    // decoupling queue so front and back stall on their own
    rtv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_q),
        .pop   (queue_b)
    );

    // back: saturation and hue dividers with the output stage
    rtv_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .work  (queue_b),
        .color (color)
    );

    // a black pixel must give zero saturation and hue despite a zero divisor
    a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
        color.valid && (color.data.brightness == '0)
        |-> (color.data.saturation == '0) && (color.data.hue == '0))
        else $error("black pixel with nonzero saturation or hue");

    // zero saturation means a gray pixel, so the hue lane must agree
    a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
        color.valid && (color.data.saturation == '0)
        |-> (color.data.hue == '0))
        else $error("zero saturation with nonzero hue");

    // a transaction into the queue leaves it non-empty on the next cycle
    a_queue_holds: assert property (@(posedge clk) disable iff (!rst_n)
        front_q.valid && front_q.ready |=> queue_b.valid)
        else $error("queue empty after a push");

endmodule
`default_nettype wire
